@@ rtl/ssms_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssms_pkg
// Shared constants and controller/datapath interface types for the stock span
// monotonic stack unit.
// ----------------------------------------------------------------------------
package ssms_pkg;

    localparam int MAX_LEN    = 1024;
    localparam int VALUE_BITS = 32;
    localparam int ADDR_W     = $clog2(MAX_LEN);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int SPAN_W     = 11;
    localparam int ENTRY_W    = VALUE_BITS + ADDR_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_LOAD
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;    // latch the incoming item, apply sequence start
        logic pop;       // drop the cached top, fetch the entry below it
        logic load_top;  // take the fetched entry as the new cached top
        logic finish;    // push the item (or flag overflow) and post the result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic pop_ok;    // stack not empty, no overflow, item >= top value
        logic out_free;  // output register can take a result this cycle
    } t_stat;

endpackage

@@ rtl/ssms_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ssms_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssms_ctrl
// Sequencer: accepts an item, pops smaller-or-equal entries one at a time,
// then pushes the item and posts its span.
// ----------------------------------------------------------------------------
module ssms_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  ssms_pkg::t_stat i_stat,
    output ssms_pkg::t_cmd  o_cmd
);

    ssms_pkg::t_state r_state;
    ssms_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssms_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            ssms_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ssms_pkg::S_CMP;
                end
            end
            ssms_pkg::S_CMP: begin
                if (i_stat.pop_ok) begin
                    o_cmd.pop = 1'b1;
                    n_state   = ssms_pkg::S_LOAD;
                end else if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ssms_pkg::S_IDLE;
                end
            end
            ssms_pkg::S_LOAD: begin
                o_cmd.load_top = 1'b1;
                n_state        = ssms_pkg::S_CMP;
            end
            default: begin
                n_state = ssms_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/ssms_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssms_datapath
// Stack memory, cached top entry, count and position counters, comparator,
// span arithmetic and the output register.
// ----------------------------------------------------------------------------
module ssms_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [31:0]                   i_sample_value,
    input  logic                          i_seq_start,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ssms_pkg::SPAN_W-1:0]   o_span,
    output logic                          o_overflow,
    input  ssms_pkg::t_cmd                i_cmd,
    output ssms_pkg::t_stat               o_stat
);

    localparam int VB = ssms_pkg::VALUE_BITS;
    localparam int AW = ssms_pkg::ADDR_W;
    localparam int CW = ssms_pkg::CNT_W;
    localparam int SW = ssms_pkg::SPAN_W;

    logic [VB-1:0] r_key;
    logic [VB-1:0] r_top_key;
    logic [AW-1:0] r_top_pos;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_pos;
    logic          r_out_vld;
    logic [SW-1:0] r_span;
    logic          r_ovf;

    logic                          ovf;
    logic                          key_ge_top;
    logic [CW-1:0]                 below_idx;
    logic [SW-1:0]                 n_span;
    logic [ssms_pkg::ENTRY_W-1:0]  rd_data;

    // Sequence full, stack compare, index of entry under the top
    assign ovf        = (r_pos >= CW'(ssms_pkg::MAX_LEN));
    assign key_ge_top = ($signed(r_key) >= $signed(r_top_key));
    assign below_idx  = r_count - CW'(2);

    assign o_stat.pop_ok   = !ovf && (r_count != '0) && key_ge_top;
    assign o_stat.out_free = !r_out_vld || !i_stall;

    // Span: distance to the greater top, or position plus one on empty stack
    always_comb begin
        if (r_count == '0) begin
            n_span = SW'(r_pos + CW'(1));
        end else begin
            n_span = SW'(r_pos - {1'b0, r_top_pos});
        end
    end

    // Stack storage: {value, position} per entry
    ssms_ram #(
        .WIDTH (ssms_pkg::ENTRY_W),
        .DEPTH (ssms_pkg::MAX_LEN)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (i_cmd.finish && !ovf),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({r_key, r_pos[AW-1:0]}),
        .i_re    (i_cmd.pop),
        .i_raddr (below_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    // Item and cached top registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key <= i_sample_value[VB-1:0];
        end
        if (i_cmd.load_top) begin
            r_top_key <= rd_data[ssms_pkg::ENTRY_W-1:AW];
            r_top_pos <= rd_data[AW-1:0];
        end else if (i_cmd.finish && !ovf) begin
            r_top_key <= r_key;
            r_top_pos <= r_pos[AW-1:0];
        end
    end

    // Stack count and position: clear on start, drop on pop, advance on push
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pos   <= '0;
        end else if (i_cmd.accept && i_seq_start) begin
            r_count <= '0;
            r_pos   <= '0;
        end else if (i_cmd.pop) begin
            r_count <= r_count - CW'(1);
        end else if (i_cmd.finish && !ovf) begin
            r_count <= r_count + CW'(1);
            r_pos   <= r_pos + CW'(1);
        end
    end

    // Output register: hold while stalled, load on finish
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_span <= ovf ? '0 : n_span;
            r_ovf  <= ovf;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_span     = r_span;
    assign o_overflow = r_ovf;

endmodule

@@ rtl/stock_span_monotonic_stack_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stock_span_monotonic_stack_unit
// Streaming stock span calculator built on a monotonic stack in RAM.
// ----------------------------------------------------------------------------
// Each input transfer carries a signed value and a start flag; each produces
// one result transfer with the span (distance back to the nearest earlier,
// strictly greater value, or position plus one if none) and an overflow flag
// for elements beyond MAX_LEN in a sequence, which report span 0. An item is
// accepted, then compared against the cached top; every stack entry it pops
// costs a further compare and a wait on the registered read of the stack RAM
// to refill the cached top entry. Every element is popped at most once in a
// sequence. The push of an item waits while a stalled result still holds the
// output register. Only one item is in work at a time, but the next item is
// taken while a result still waits in the output register. No clearing pass
// is needed after reset.
module stock_span_monotonic_stack_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [31:0]                 i_sample_value,
    input  logic                        i_seq_start,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [ssms_pkg::SPAN_W-1:0] o_span,
    output logic                        o_overflow
);

    ssms_pkg::t_cmd  cmd;
    ssms_pkg::t_stat stat;

    ssms_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    ssms_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_value (i_sample_value),
        .i_seq_start    (i_seq_start),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_span         (o_span),
        .o_overflow     (o_overflow),
        .i_cmd          (cmd),
        .o_stat         (stat)
    );

endmodule

@@ rtl/ssms_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssms_checker
// Port-level checks for the stock span unit, bound to the top level.
// ----------------------------------------------------------------------------
module ssms_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [ssms_pkg::SPAN_W-1:0] o_span,
    input logic                        o_overflow
);

    // One item in work at a time: input stalls right after a transfer
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken while an item is in work");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_span) && $stable(o_overflow)))
        else $error("stalled result changed");

    // Overflow results carry span zero
    a_ovf_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (o_span == '0))
        else $error("overflow result with nonzero span");

    // Normal results have a span of at least one, at most MAX_LEN
    a_span_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_overflow) |->
            ((o_span != '0) && (o_span <= ssms_pkg::SPAN_W'(ssms_pkg::MAX_LEN))))
        else $error("span out of range");

endmodule

bind stock_span_monotonic_stack_unit ssms_checker u_ssms_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_span     (o_span),
    .o_overflow (o_overflow)
);

@@ tb/sv/stock_span_monotonic_stack_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stock_span_monotonic_stack_unit_tb
// Self-checking bench for the stock span monotonic stack unit.
// ----------------------------------------------------------------------------
// A short table of hand-picked transfers comes first. It covers the value
// extremes, equal values, the start flag and the no-greater-value case. A
// long random run follows, made mostly of well-formed sequences with shaped
// values. One sequence runs past the length limit, so its top element reaches
// the widest span and the items after it overflow. A small span model, kept
// inside the bench, predicts every result not typed in. Both sides idle at random.
// ----------------------------------------------------------------------------
module stock_span_monotonic_stack_unit_tb;

    localparam int SPAN_W  = ssms_pkg::SPAN_W;
    localparam int MAX_LEN = ssms_pkg::MAX_LEN;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 32;
    localparam int RANDOM_ITEMS   = 1950;
    localparam int DIR_ROWS_N     = 21;

    typedef struct packed {
        logic [SPAN_W-1:0] span;
        logic              ovf;
    } t_span_result;

    typedef struct packed {
        logic [31:0]       value;
        logic              start;
        logic              fixed;   // 1: the expected result is typed in below
        logic [SPAN_W-1:0] span;
        logic              ovf;
    } t_dir_row;

    typedef enum int {
        VM_RANDOM,
        VM_NARROW,
        VM_RISING,
        VM_FALLING,
        VM_CORNER
    } t_value_mode;

    // Directed stimulus: value, start, fixed, span, overflow
    localparam t_dir_row DIR_ROWS [DIR_ROWS_N] = '{
        '{32'h0000_0005, 1'b1, 1'b1, 11'd1, 1'b0},  // start flag right after reset
        '{32'h8000_0000, 1'b0, 1'b1, 11'd1, 1'b0},  // most negative value
        '{32'h7FFF_FFFF, 1'b0, 1'b1, 11'd3, 1'b0},  // most positive, nothing greater
        '{32'h7FFF_FFFF, 1'b0, 1'b1, 11'd4, 1'b0},  // equal value counts
        '{32'h0000_0000, 1'b0, 1'b1, 11'd1, 1'b0},
        '{32'h0000_0000, 1'b0, 1'b1, 11'd2, 1'b0},
        '{32'hFFFF_FFFF, 1'b0, 1'b1, 11'd1, 1'b0},
        '{32'h0000_0003, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'hFFFF_FFF9, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'h0000_0002, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'h0000_0064, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'h8000_0000, 1'b1, 1'b1, 11'd1, 1'b0},  // restart mid-stream
        '{32'h8000_0000, 1'b0, 1'b1, 11'd2, 1'b0},
        '{32'h8000_0000, 1'b0, 1'b1, 11'd3, 1'b0},
        '{32'h5555_5555, 1'b0, 1'b1, 11'd4, 1'b0},
        '{32'hAAAA_AAAA, 1'b0, 1'b1, 11'd1, 1'b0},
        '{32'h0000_0001, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'hFFFF_0000, 1'b1, 1'b1, 11'd1, 1'b0},
        '{32'h0000_FFFF, 1'b0, 1'b1, 11'd2, 1'b0},
        '{32'h7FFF_FFFE, 1'b0, 1'b1, 11'd3, 1'b0},
        '{32'h7FFF_FFFF, 1'b0, 1'b1, 11'd4, 1'b0}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [31:0]       i_sample_value;
    logic              i_seq_start;
    logic              o_valid;
    logic              i_stall;
    logic [SPAN_W-1:0] o_span;
    logic              o_overflow;

    // Side data that travels with the payload of the current transfer
    logic              cur_fixed;
    logic [SPAN_W-1:0] cur_span;
    logic              cur_ovf;

    // Span model state
    logic signed [31:0] stack_val [MAX_LEN];
    int                 stack_pos [MAX_LEN];
    int                 depth   = 0;
    int                 seq_pos = 0;

    t_span_result pending_spans [$];
    int           err_cnt     = 0;
    int           idle_cycles = 0;
    int           items_sent  = 0;
    int           hold_req    = 0;
    int           hold_done   = 0;
    logic         burst_mode  = 1'b0;

    stock_span_monotonic_stack_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample_value (i_sample_value),
        .i_seq_start    (i_seq_start),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_span         (o_span),
        .o_overflow     (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Advance the span model by one element and return its result
    function automatic t_span_result calc_span(input logic [31:0] raw, input logic start);
        t_span_result       r;
        logic signed [31:0] v;
        v = raw;
        if (start) begin
            depth   = 0;
            seq_pos = 0;
        end
        if (seq_pos >= MAX_LEN) begin
            r.span = '0;
            r.ovf  = 1'b1;
            return r;
        end
        while (depth > 0 && v >= stack_val[depth-1])
            depth--;
        if (depth == 0)
            r.span = SPAN_W'(seq_pos + 1);
        else
            r.span = SPAN_W'(seq_pos - stack_pos[depth-1]);
        stack_val[depth] = v;
        stack_pos[depth] = seq_pos;
        depth++;
        seq_pos++;
        r.ovf = 1'b0;
        return r;
    endfunction

    // Sender gap: mostly none or short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (burst_mode || roll < 50)
            return 0;
        else if (roll < 88)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_value(input t_value_mode mode, input int idx);
        int v;
        case (mode)
            VM_NARROW:  v = int'($urandom_range(0, 6)) - 3;
            VM_RISING:  v = idx * 4 + int'($urandom_range(0, 10)) - 2;
            VM_FALLING: v = 100000 - idx * 3 + int'($urandom_range(0, 4));
            VM_CORNER: begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 0;
                    3:       v = -1;
                    default: v = 1;
                endcase
            end
            default:    v = $urandom;
        endcase
        return v;
    endfunction

    // Offer one transfer and hold it until it is taken
    task automatic drive_item(input logic [31:0] value, input logic start, input logic fixed,
                              input logic [SPAN_W-1:0] span, input logic ovf);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_sample_value <= value;
        i_seq_start    <= start;
        cur_fixed      <= fixed;
        cur_span       <= span;
        cur_ovf        <= ovf;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    // Short random sequence, with an occasional restart in the middle
    task automatic drive_short_seq();
        t_value_mode mode;
        int          len;
        logic        start;
        mode       = t_value_mode'($urandom_range(0, 4));
        len        = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
        burst_mode = ($urandom_range(0, 4) == 0);
        for (int k = 0; k < len; k++) begin
            start = (k == 0) || ($urandom_range(0, 31) == 0);
            if ($urandom_range(0, 9) == 0)
                mode = t_value_mode'($urandom_range(0, 4));
            drive_item(pick_value(mode, k), start, 1'b0, '0, 1'b0);
        end
    endtask

    // Drop the offer and wait until every expected result is back
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_spans.size() != 0)
            @(negedge i_clk);
    endtask

    // Receiver: random stall runs, plus a long hold-off on request
    initial begin
        int roll;
        int run;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_done) begin
                hold_done = hold_req;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_stall <= 1'b0;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 30) begin
                    i_stall <= 1'b0;
                    run = $urandom_range(10, 60);
                end else if (roll < 70) begin
                    i_stall <= 1'b0;
                    run = $urandom_range(0, 3);
                end else if (roll < 95) begin
                    i_stall <= 1'b1;
                    run = $urandom_range(0, 3);
                end else begin
                    i_stall <= 1'b1;
                    run = $urandom_range(10, 40);
                end
                repeat (run) @(negedge i_clk);
            end
        end
    end

    // Check results, predict on each input transfer, watch for a hang
    always @(posedge i_clk) begin
        t_span_result got;
        t_span_result want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got.span = o_span;
                got.ovf  = o_overflow;
                if (pending_spans.size() == 0) begin
                    err_cnt++;
                    $display("%0t: result with none pending, span %0d overflow %0b",
                             $realtime, o_span, o_overflow);
                end else begin
                    want = pending_spans.pop_front();
                    if (got.span !== want.span) begin
                        err_cnt++;
                        $display("%0t: span mismatch, expected %0d, got %0d",
                                 $realtime, want.span, got.span);
                    end
                    if (got.ovf !== want.ovf) begin
                        err_cnt++;
                        $display("%0t: overflow mismatch, expected %0b, got %0b",
                                 $realtime, want.ovf, got.ovf);
                    end
                end
            end
            if (i_valid && !o_stall) begin
                want = calc_span(i_sample_value, i_seq_start);
                if (cur_fixed) begin
                    want.span = cur_span;
                    want.ovf  = cur_ovf;
                end
                pending_spans = {pending_spans, want};
            end
            if ((o_valid && !i_stall) || (i_valid && !o_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_sample_value = '0;
        i_seq_start    = 1'b0;
        cur_fixed      = 1'b0;
        cur_span       = '0;
        cur_ovf        = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        for (int r = 0; r < DIR_ROWS_N; r++)
            drive_item(DIR_ROWS[r].value, DIR_ROWS[r].start, DIR_ROWS[r].fixed,
                       DIR_ROWS[r].span, DIR_ROWS[r].ovf);
        wait_drained();

        // Short sequences; hold the receiver off once while offers continue
        while (items_sent < DIR_ROWS_N + 450) begin
            if (items_sent >= DIR_ROWS_N + 200 && hold_req == 0)
                hold_req++;
            drive_short_seq();
        end

        // Pause the sender until every result is back
        wait_drained();

        // Run one sequence past the length limit: deep stack, widest span, overflow
        burst_mode = 1'b0;
        for (int k = 0; k < MAX_LEN - 1; k++)
            drive_item(($urandom_range(0, 3) == 0) ? $urandom : pick_value(VM_FALLING, k),
                       (k == 0), 1'b0, '0, 1'b0);
        drive_item(32'h7FFF_FFFF, 1'b0, 1'b1, SPAN_W'(MAX_LEN), 1'b0);
        for (int k = 0; k < 6; k++)
            drive_item($urandom, 1'b0, 1'b1, '0, 1'b1);

        // More short sequences to finish
        while (items_sent < DIR_ROWS_N + RANDOM_ITEMS)
            drive_short_seq();

        @(negedge i_clk);
        i_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0 && pending_spans.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
